// ===== hdl/kinetic_phase_factor_generator_assert.svh =====
// Assertion macros shared by the RTL.
`ifndef KINETIC_PHASE_FACTOR_GENERATOR_ASSERT_SVH
`define KINETIC_PHASE_FACTOR_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge outside reset.
`define KPFG_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("kpfg assertion failed");

// Antecedent implies consequent in the same cycle.
`define KPFG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kpfg assertion failed");

`else

`define KPFG_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define KPFG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/kpf_pkg.sv =====
`timescale 1ns / 1ps

package kpf_pkg;

	localparam int AXES = 3;
	localparam int IDX_W = 6;
	localparam int IDX_N = 1 << IDX_W;
	localparam int SQ_W = 2 * IDX_W;
	localparam int COEF_W = 32;
	localparam int POINTS_DEFAULT = 64;
	localparam logic [COEF_W-1:0] COEF_RESET = 32'd168662;

	localparam int ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_COEF_X = 2'd0;
	localparam logic [ADDR_W-1:0] REG_COEF_Y = 2'd1;
	localparam logic [ADDR_W-1:0] REG_COEF_Z = 2'd2;

	localparam int U_W = 31;
	localparam int WORD_W = 32;
	localparam logic [U_W-1:0] Q30_ONE = 31'h4000_0000;
	localparam logic [U_W-1:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int ITERS = 5;
	localparam int DIV_W = 7;
	localparam int RECIP_W = 30;
	localparam logic [DIV_W-1:0] TAYLOR_DIV [ITERS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [RECIP_W-1:0] TAYLOR_RECIP [ITERS] = '{
		30'(64'h1_0000_0000 / 64'd110),
		30'(64'h1_0000_0000 / 64'd72),
		30'(64'h1_0000_0000 / 64'd42),
		30'(64'h1_0000_0000 / 64'd20),
		30'(64'h1_0000_0000 / 64'd6)
	};

	localparam int MAG_W = 15;
	localparam int OUT_W = 16;

	localparam int ST_SQ = 0;
	localparam int ST_MUL = 1;
	localparam int ST_SUM = 2;
	localparam int ST_X = 3;
	localparam int ST_X2 = 4;
	localparam int ST_TERM = 5;
	localparam int ST_S = ST_TERM + 3 * ITERS;
	localparam int ST_OUT = ST_S + 1;
	localparam int PIPE_STAGES = ST_OUT + 1;

	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [U_W-1:0] u_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0] quad_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic [IDX_W-1:0] x_index;
		logic [IDX_W-1:0] y_index;
		logic [IDX_W-1:0] z_index;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] factor_real;
		logic signed [OUT_W-1:0] factor_imag;
	} factor_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [COEF_W-1:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] en;
		logic [PIPE_STAGES-1:0] vld;
	} ctl_t;

endpackage

// ===== hdl/kpf_chan_if.sv =====
`timescale 1ns / 1ps

interface kpf_chan_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/kpf_ctrl.sv =====
`timescale 1ns / 1ps

module kpf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_ready,
	output kpf_pkg::ctl_t ctl
);
	localparam int N = kpf_pkg::PIPE_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] en;

	// advance a stage when it is empty or its successor advances
	assign en[N-1] = ~vld_q[N-1] | out_ready;
	for (genvar i = 0; i < N - 1; i++) begin : gen_en
		assign en[i] = ~vld_q[i] | en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < N; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ctl.en = en;
	assign ctl.vld = vld_q;
endmodule

// ===== hdl/kpf_phase.sv =====
`timescale 1ns / 1ps

module kpf_phase #(
	parameter int POINTS_X = kpf_pkg::POINTS_DEFAULT,
	parameter int POINTS_Y = kpf_pkg::POINTS_DEFAULT,
	parameter int POINTS_Z = kpf_pkg::POINTS_DEFAULT
) (
	input logic clk,
	input logic [kpf_pkg::PIPE_STAGES-1:0] en,
	input kpf_pkg::point_t point,
	input kpf_pkg::coef_t coef [kpf_pkg::AXES],
	output kpf_pkg::quad_t quad_s3,
	output kpf_pkg::u_t u_sin_s3,
	output kpf_pkg::u_t u_cos_s3
);
	localparam int PTS [kpf_pkg::AXES] = '{POINTS_X, POINTS_Y, POINTS_Z};

	kpf_pkg::sq_t sq_tab [kpf_pkg::AXES][kpf_pkg::IDX_N];
	logic [kpf_pkg::IDX_W-1:0] idx [kpf_pkg::AXES];
	kpf_pkg::sq_t msq_s1 [kpf_pkg::AXES];
	kpf_pkg::coef_t prod_s2 [kpf_pkg::AXES];
	kpf_pkg::coef_t theta;
	kpf_pkg::u_t frac;

	// squared signed frequency of every bin, per axis
	for (genvar a = 0; a < kpf_pkg::AXES; a++) begin : gen_axis
		for (genvar g = 0; g < kpf_pkg::IDX_N; g++) begin : gen_bin
			localparam int BIN = g % PTS[a];
			localparam int MAG = (BIN < PTS[a] / 2) ? BIN : PTS[a] - BIN;
			assign sq_tab[a][g] = kpf_pkg::sq_t'(MAG * MAG);
		end
	end

	assign idx[0] = point.x_index;
	assign idx[1] = point.y_index;
	assign idx[2] = point.z_index;

	always_ff @(posedge clk) begin
		for (int a = 0; a < kpf_pkg::AXES; a++) begin
			if (en[kpf_pkg::ST_SQ]) begin
				msq_s1[a] <= sq_tab[a][idx[a]];
			end
			if (en[kpf_pkg::ST_MUL]) begin
				prod_s2[a] <= kpf_pkg::coef_t'(coef[a] * msq_s1[a]);
			end
		end
	end

	// wrap modulo one turn
	assign theta = prod_s2[0] + prod_s2[1] + prod_s2[2];
	assign frac = {1'b0, theta[29:0]};

	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_SUM]) begin
			quad_s3 <= theta[31:30];
			u_sin_s3 <= frac;
			u_cos_s3 <= kpf_pkg::Q30_ONE - frac;
		end
	end
endmodule

// ===== hdl/kpf_qsin.sv =====
`timescale 1ns / 1ps

module kpf_qsin (
	input logic clk,
	input logic [kpf_pkg::PIPE_STAGES-1:0] en,
	input kpf_pkg::u_t u,
	output kpf_pkg::u_t s_s21
);
	localparam int ITERS = kpf_pkg::ITERS;

	logic [61:0] px_full;
	logic [61:0] xx_full;
	logic [61:0] sp_full;
	kpf_pkg::u_t x_s4;
	kpf_pkg::u_t x_s5;
	kpf_pkg::word_t x2_s5;
	kpf_pkg::u_t t_chain [ITERS+1];
	kpf_pkg::u_t x_chain [ITERS+1];
	kpf_pkg::word_t x2_chain [ITERS+1];

	// angle in radians, Q1.30
	assign px_full = u * kpf_pkg::HALF_PI_Q30;
	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_X]) begin
			x_s4 <= px_full[60:30];
		end
	end

	assign xx_full = x_s4 * x_s4;
	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_X2]) begin
			x2_s5 <= xx_full[61:30];
			x_s5 <= x_s4;
		end
	end

	assign t_chain[0] = kpf_pkg::Q30_ONE;
	assign x_chain[0] = x_s5;
	assign x2_chain[0] = x2_s5;

	// nested series, one term per three stages
	for (genvar k = 0; k < ITERS; k++) begin : gen_term
		localparam int BASE = kpf_pkg::ST_TERM + 3 * k;

		logic [62:0] xt_full;
		logic [61:0] pr_full;
		logic [36:0] kq_full;
		kpf_pkg::word_t p_s1;
		kpf_pkg::word_t p_s2;
		kpf_pkg::word_t rem;
		logic [kpf_pkg::RECIP_W-1:0] quo_s2;
		logic [kpf_pkg::RECIP_W-1:0] quo;
		kpf_pkg::u_t x_s1;
		kpf_pkg::u_t x_s2;
		kpf_pkg::u_t x_s3;
		kpf_pkg::word_t x2_s1;
		kpf_pkg::word_t x2_s2;
		kpf_pkg::word_t x2_s3;
		kpf_pkg::u_t t_s3;

		assign xt_full = x2_chain[k] * t_chain[k];
		always_ff @(posedge clk) begin
			if (en[BASE]) begin
				p_s1 <= xt_full[61:30];
				x_s1 <= x_chain[k];
				x2_s1 <= x2_chain[k];
			end
		end

		// quotient estimate by reciprocal, low by at most one
		assign pr_full = p_s1 * kpf_pkg::TAYLOR_RECIP[k];
		always_ff @(posedge clk) begin
			if (en[BASE+1]) begin
				quo_s2 <= pr_full[61:32];
				p_s2 <= p_s1;
				x_s2 <= x_s1;
				x2_s2 <= x2_s1;
			end
		end

		assign kq_full = quo_s2 * kpf_pkg::TAYLOR_DIV[k];
		assign rem = p_s2 - kq_full[31:0];
		assign quo = quo_s2 +
			((rem >= {25'd0, kpf_pkg::TAYLOR_DIV[k]}) ? 30'd1 : 30'd0);
		always_ff @(posedge clk) begin
			if (en[BASE+2]) begin
				t_s3 <= kpf_pkg::Q30_ONE - {1'b0, quo};
				x_s3 <= x_s2;
				x2_s3 <= x2_s2;
			end
		end

		assign t_chain[k+1] = t_s3;
		assign x_chain[k+1] = x_s3;
		assign x2_chain[k+1] = x2_s3;
	end

	assign sp_full = x_chain[ITERS] * t_chain[ITERS];
	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_S]) begin
			s_s21 <= sp_full[60:30];
		end
	end
endmodule

// ===== hdl/kpf_out.sv =====
`timescale 1ns / 1ps

module kpf_out (
	input logic clk,
	input logic [kpf_pkg::PIPE_STAGES-1:0] en,
	input kpf_pkg::quad_t quad,
	input kpf_pkg::u_t s_sin,
	input kpf_pkg::u_t s_cos,
	output kpf_pkg::factor_t factor_s22
);
	localparam kpf_pkg::quad_t QUAD_FIRST = 2'd0;
	localparam kpf_pkg::quad_t QUAD_SECOND = 2'd1;
	localparam kpf_pkg::quad_t QUAD_THIRD = 2'd2;
	localparam kpf_pkg::quad_t QUAD_FOURTH = 2'd3;

	kpf_pkg::quad_t quad_s [kpf_pkg::ST_X:kpf_pkg::ST_S];
	kpf_pkg::mag_t mag_sin;
	kpf_pkg::mag_t mag_cos;
	kpf_pkg::mag_t smag;
	kpf_pkg::mag_t cmag;
	logic sneg;
	logic cneg;
	logic [kpf_pkg::OUT_W-1:0] re_pos;
	logic [kpf_pkg::OUT_W-1:0] im_pos;

	function automatic kpf_pkg::mag_t round_sat(input kpf_pkg::u_t s);
		logic [31:0] sum;
		sum = {1'b0, s} + 32'h0000_4000;
		return (sum[31:15] > 17'd32767) ? 15'h7fff : sum[29:15];
	endfunction

	// carry the quadrant alongside the series lanes
	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_X]) begin
			quad_s[kpf_pkg::ST_X] <= quad;
		end
		for (int i = kpf_pkg::ST_X + 1; i <= kpf_pkg::ST_S; i++) begin
			if (en[i]) begin
				quad_s[i] <= quad_s[i-1];
			end
		end
	end

	assign mag_sin = round_sat(s_sin);
	assign mag_cos = round_sat(s_cos);

	always_comb begin
		unique case (quad_s[kpf_pkg::ST_S])
			QUAD_FIRST: begin
				smag = mag_sin; sneg = 1'b0; cmag = mag_cos; cneg = 1'b0;
			end
			QUAD_SECOND: begin
				smag = mag_cos; sneg = 1'b0; cmag = mag_sin; cneg = 1'b1;
			end
			QUAD_THIRD: begin
				smag = mag_sin; sneg = 1'b1; cmag = mag_cos; cneg = 1'b1;
			end
			QUAD_FOURTH: begin
				smag = mag_cos; sneg = 1'b1; cmag = mag_sin; cneg = 1'b0;
			end
		endcase
	end

	assign re_pos = {1'b0, cmag};
	assign im_pos = {1'b0, smag};

	// imaginary part is the negated sine
	always_ff @(posedge clk) begin
		if (en[kpf_pkg::ST_OUT]) begin
			factor_s22.factor_real <= cneg ? (16'd0 - re_pos) : re_pos;
			factor_s22.factor_imag <= sneg ? im_pos : (16'd0 - im_pos);
		end
	end
endmodule

// ===== hdl/kinetic_phase_factor_generator.sv =====
`timescale 1ns / 1ps
// channel  role    payload                                accepted at edge with
// point    sink    x_index, y_index, z_index (6 b each)   point.valid && point.ready
// factor   source  factor_real, factor_imag (16 b signed) factor.valid && factor.ready
// cfg      sink    addr (2 b), wdata (32 b)               cfg.valid && cfg.ready
//
// One item per cycle while factor is ready; 22 register stages, result offered from the last stage.
// Most stages belong to the sine series, five nested steps of three stages each (multiply,
// reciprocal multiply, correct), sine and cosine lanes side by side.
// Reset clears every stage valid bit and loads each coefficient with 168662; cfg is always ready.
// A stall at factor halts each full stage up to the nearest empty one, while empty stages keep taking items.

`include "kinetic_phase_factor_generator_assert.svh"

module kinetic_phase_factor_generator #(
	parameter int POINTS_X = kpf_pkg::POINTS_DEFAULT,
	parameter int POINTS_Y = kpf_pkg::POINTS_DEFAULT,
	parameter int POINTS_Z = kpf_pkg::POINTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	kpf_chan_if.sink point,
	kpf_chan_if.source factor,
	kpf_chan_if.sink cfg
);
	kpf_pkg::coef_t coef_q [kpf_pkg::AXES];
	kpf_pkg::ctl_t ctl;
	kpf_pkg::quad_t quad_s3;
	kpf_pkg::u_t u_sin_s3;
	kpf_pkg::u_t u_cos_s3;
	kpf_pkg::u_t s_sin_s21;
	kpf_pkg::u_t s_cos_s21;
	kpf_pkg::factor_t factor_s22;
	kpf_pkg::point_t point_data;
	kpf_pkg::cfg_t cfg_data;

	assign point_data = point.data;
	assign cfg_data = cfg.data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{default: kpf_pkg::COEF_RESET};
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_data.addr)
				kpf_pkg::REG_COEF_X: coef_q[0] <= cfg_data.wdata;
				kpf_pkg::REG_COEF_Y: coef_q[1] <= cfg_data.wdata;
				kpf_pkg::REG_COEF_Z: coef_q[2] <= cfg_data.wdata;
				default: begin
				end
			endcase
		end
	end

	kpf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(point.valid),
		.out_ready(factor.ready),
		.ctl(ctl)
	);

	kpf_phase #(
		.POINTS_X(POINTS_X),
		.POINTS_Y(POINTS_Y),
		.POINTS_Z(POINTS_Z)
	) u_phase (
		.clk(clk),
		.en(ctl.en),
		.point(point_data),
		.coef(coef_q),
		.quad_s3(quad_s3),
		.u_sin_s3(u_sin_s3),
		.u_cos_s3(u_cos_s3)
	);

	kpf_qsin u_sin (
		.clk(clk),
		.en(ctl.en),
		.u(u_sin_s3),
		.s_s21(s_sin_s21)
	);

	kpf_qsin u_cos (
		.clk(clk),
		.en(ctl.en),
		.u(u_cos_s3),
		.s_s21(s_cos_s21)
	);

	kpf_out u_out (
		.clk(clk),
		.en(ctl.en),
		.quad(quad_s3),
		.s_sin(s_sin_s21),
		.s_cos(s_cos_s21),
		.factor_s22(factor_s22)
	);

	assign point.ready = ctl.en[kpf_pkg::ST_SQ];
	assign factor.valid = ctl.vld[kpf_pkg::ST_OUT];
	assign factor.data = factor_s22;

	`KPFG_ASSERT_ALWAYS(a_ready_when_drained, clk, arst_n, factor.valid || point.ready)
	`KPFG_ASSERT_IMP(a_no_min_code, clk, arst_n, factor.valid, (factor_s22.factor_real != 16'sh8000) && (factor_s22.factor_imag != 16'sh8000))
	`KPFG_ASSERT_IMP(a_unit_magnitude, clk, arst_n, factor.valid, (factor_s22.factor_real >= 16'sd23000) || (factor_s22.factor_real <= -16'sd23000) || (factor_s22.factor_imag >= 16'sd23000) || (factor_s22.factor_imag <= -16'sd23000))
endmodule
